>>> sv/pwrcd_pkg.sv
// Package for the pulse-width remote code decoder: payload structs, pulse class,
// decoder phase enum, register indexes and fixed constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwrcd_pkg;

   localparam int DURATION_WIDTH  = 16;
   localparam int INTERVAL_WIDTH  = 12;
   localparam int TOL_WIDTH       = 10;
   localparam int BIT_COUNT_WIDTH = 7;
   localparam int CODE_MAX_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 12;
   localparam int QUEUE_DEPTH     = 2;

   // preamble window and end gap, in short intervals
   localparam int PRE_MIN_MULT = 29;
   localparam int PRE_MAX_MULT = 49;
   localparam int END_MULT     = 10;

   // register reset values
   localparam logic [INTERVAL_WIDTH-1:0]  SHORT_RESET = 12'd150;
   localparam logic [INTERVAL_WIDTH-1:0]  LONG_RESET  = 12'd450;
   localparam logic [TOL_WIDTH-1:0]       TOL_RESET   = 10'd50;
   localparam logic [BIT_COUNT_WIDTH-1:0] MINB_RESET  = 7'd12;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_INTERVAL = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_INTERVAL  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE      = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_BITS       = 8'd3;

   typedef struct packed {
      logic                      level;
      logic [DURATION_WIDTH-1:0] duration;
   } req_payload_type;

   typedef struct packed {
      logic [CODE_MAX_WIDTH-1:0]  code;
      logic [BIT_COUNT_WIDTH-1:0] bit_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [INTERVAL_WIDTH-1:0]  short_interval;
      logic [INTERVAL_WIDTH-1:0]  long_interval;
      logic [TOL_WIDTH-1:0]       tolerance;
      logic [BIT_COUNT_WIDTH-1:0] min_bits;
   } cfg_type;

   // one classified pulse as it travels through the queue
   typedef struct packed {
      logic level;
      logic preamble;    // low pulse inside the preamble window
      logic end_gap;     // at or above the end-of-frame gap
      logic near_short;  // within tolerance of the short interval
      logic near_long;   // within tolerance of the long interval
   } pulse_class_type;

   typedef enum logic [1:0] {
      PHASE_HUNT      = 2'd0,
      PHASE_WAIT_HIGH = 2'd1,
      PHASE_WAIT_LOW  = 2'd2
   } phase_type;

endpackage

`default_nettype wire

>>> sv/pwrcd_front.sv
// Front end: classifies one measured pulse against the current intervals.
// Depends on pwrcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwrcd_front (
   input  wire pwrcd_pkg::cfg_type         cfg,
   input  wire pwrcd_pkg::req_payload_type pulse,
   output pwrcd_pkg::pulse_class_type      pulse_class
);
   import pwrcd_pkg::*;

   logic [16:0] d_ext;
   logic [16:0] d_plus_tol;
   logic [16:0] s_ext;
   logic [16:0] l_ext;
   logic [16:0] tol_ext;
   logic [16:0] pre_min;
   logic [17:0] pre_max;
   logic [16:0] end_gap;

   always_comb begin
      d_ext      = {1'b0, pulse.duration};
      tol_ext    = 17'(cfg.tolerance);
      s_ext      = 17'(cfg.short_interval);
      l_ext      = 17'(cfg.long_interval);
      d_plus_tol = d_ext + tol_ext;
      // lower bounds moved to the duration side so nothing goes negative
      pre_min    = s_ext * 17'(PRE_MIN_MULT);
      pre_max    = 18'(s_ext) * 18'(PRE_MAX_MULT) + 18'(tol_ext);
      end_gap    = s_ext * 17'(END_MULT) + tol_ext;

      pulse_class.level      = pulse.level;
      pulse_class.preamble   = !pulse.level && (d_plus_tol >= pre_min)
                               && (18'(d_ext) <= pre_max);
      pulse_class.end_gap    = d_ext >= end_gap;
      pulse_class.near_short = (d_plus_tol >= s_ext) && (d_ext <= s_ext + tol_ext);
      pulse_class.near_long  = (d_plus_tol >= l_ext) && (d_ext <= l_ext + tol_ext);
   end

endmodule

`default_nettype wire

>>> sv/pwrcd_queue.sv
// Short FIFO of classified pulses between front and back end.
// Depends on pwrcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwrcd_queue (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             push,
   input  wire pwrcd_pkg::pulse_class_type push_data,
   output logic                            full,
   input  wire                             pop,
   output logic                            not_empty,
   output pwrcd_pkg::pulse_class_type      pop_data
);
   import pwrcd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pulse_class_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/pwrcd_back.sv
// Back end: frame state machine, code shift register and result register.
// Depends on pwrcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwrcd_back #(
   parameter int CODE_WIDTH = 64
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire [pwrcd_pkg::BIT_COUNT_WIDTH-1:0]         min_bits,
   input  wire                                          item_valid,
   input  wire pwrcd_pkg::pulse_class_type              item,
   output logic                                         item_pop,
   output logic                                         rsp_valid,
   input  wire                                          rsp_stall,
   output pwrcd_pkg::rsp_payload_type                   rsp_data
);
   import pwrcd_pkg::*;

   localparam int CNT_W = $clog2(CODE_WIDTH + 1);

   phase_type              phase_ff, phase_in;
   logic [CODE_WIDTH-1:0]  code_ff, code_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   h_short_ff, h_short_in;
   logic                   h_long_ff, h_long_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   clear_frame;
   logic                   shift_bit;
   logic                   bit_value;
   logic                   keep_high;
   logic                   emit;
   logic                   bit_zero, bit_one;

   assign item_pop  = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign bit_zero  = h_short_ff && item.near_long;
   assign bit_one   = h_long_ff && item.near_short;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item_pop) begin
         case (phase_ff)
            PHASE_WAIT_HIGH: begin
               if (item.level) phase_in = PHASE_WAIT_LOW;
            end
            PHASE_WAIT_LOW: begin
               if (!item.level && (item.end_gap || bit_zero || bit_one)) begin
                  phase_in = PHASE_WAIT_HIGH;
               end else begin
                  phase_in = PHASE_HUNT;
               end
            end
            default: begin
               phase_in = (!item.level && item.preamble) ? PHASE_WAIT_HIGH : PHASE_HUNT;
            end
         endcase
      end
   end

   // datapath actions for the popped beat
   always_comb begin
      clear_frame = 1'b0;
      shift_bit   = 1'b0;
      bit_value   = 1'b0;
      keep_high   = 1'b0;
      emit        = 1'b0;
      if (item_pop) begin
         case (phase_ff)
            PHASE_WAIT_HIGH: begin
               keep_high = item.level;
            end
            PHASE_WAIT_LOW: begin
               if (!item.level) begin
                  if (item.end_gap) begin
                     clear_frame = 1'b1;
                     emit        = BIT_COUNT_WIDTH'(cnt_ff) >= min_bits;
                  end else if (bit_zero) begin
                     shift_bit = 1'b1;
                  end else if (bit_one) begin
                     shift_bit = 1'b1;
                     bit_value = 1'b1;
                  end
               end
            end
            default: begin
               clear_frame = !item.level && item.preamble;
            end
         endcase
      end
   end

   always_comb begin
      code_in    = code_ff;
      cnt_in     = cnt_ff;
      h_short_in = h_short_ff;
      h_long_in  = h_long_ff;
      if (clear_frame) begin
         code_in = '0;
         cnt_in  = '0;
      end else if (shift_bit) begin
         code_in = {code_ff[CODE_WIDTH-2:0], bit_value};
         if (cnt_ff != CNT_W'(CODE_WIDTH)) cnt_in = cnt_ff + 1'b1;
      end
      if (keep_high) begin
         h_short_in = item.near_short;
         h_long_in  = item.near_long;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.code      = CODE_MAX_WIDTH'(code_ff);
         rsp_data_in.bit_count = BIT_COUNT_WIDTH'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HUNT;
         code_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         code_ff      <= code_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_short_ff  <= h_short_in;
      h_long_ff   <= h_long_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CODE_WIDTH))
      else $error("bit counter above code width");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> (cnt_ff == '0) && (code_ff == '0) && rsp_valid_ff)
      else $error("frame not cleared after emit");

   a_emit_from_low: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff == PHASE_WAIT_LOW) && !item.level)
      else $error("result raised outside end gap");

   a_no_pop_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !item_pop)
      else $error("beat consumed while result stalled");

endmodule

`default_nettype wire

>>> sv/pulse_width_remote_code_decoder_top.sv
// The closing low pulse goes through the queue and the back end into the result register.
// Throughput: one pulse per cycle while no stalled result fills the 2-beat queue.
// A stalled result holds the back end; the front keeps taking pulses until the queue fills.
// Reset is synchronous, active high: clears phase, counters, queue and result valid,
// and loads the register defaults 150 / 450 / 50 / 12. No clearing pass is needed.
// Depends on pwrcd_pkg, pwrcd_front, pwrcd_queue, pwrcd_back.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_remote_code_decoder_top #(
   parameter int CODE_WIDTH = 64   // 12 .. 64, upper code bits read zero
) (
   input  wire                                      clock,
   input  wire                                      reset,
   // pulse input channel
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire pwrcd_pkg::req_payload_type          req_data,
   // decoded code channel
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output pwrcd_pkg::rsp_payload_type               rsp_data,
   // register write channel
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire [pwrcd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire [pwrcd_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import pwrcd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   pulse_class_type  front_class;
   pulse_class_type  queue_head;
   logic             queue_full;
   logic             queue_not_empty;
   logic             queue_pop;

   // registers: always ready, index beyond the list is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SHORT_INTERVAL: cfg_in.short_interval = INTERVAL_WIDTH'(csr_data);
            CSR_LONG_INTERVAL:  cfg_in.long_interval  = INTERVAL_WIDTH'(csr_data);
            CSR_TOLERANCE:      cfg_in.tolerance      = TOL_WIDTH'(csr_data);
            CSR_MIN_BITS:       cfg_in.min_bits       = BIT_COUNT_WIDTH'(csr_data);
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_interval <= SHORT_RESET;
         cfg_ff.long_interval  <= LONG_RESET;
         cfg_ff.tolerance      <= TOL_RESET;
         cfg_ff.min_bits       <= MINB_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify the incoming beat, push straight into the queue
   pwrcd_front u_front (
      .cfg         (cfg_ff),
      .pulse       (req_data),
      .pulse_class (front_class)
   );

   // input stalls only when the queue is full
   assign req_stall = queue_full;

   pwrcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_class),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_head)
   );

   // back: frame sequencing and result register
   pwrcd_back #(
      .CODE_WIDTH (CODE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .min_bits   (cfg_ff.min_bits),
      .item_valid (queue_not_empty),
      .item       (queue_head),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

>>> verif/pulse_width_remote_code_decoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pulse_width_remote_code_decoder_top: directed and random pulse
// trains, checked beat by beat against a decoder model kept inside the bench.
// Depends on pwrcd_pkg and the decoder RTL.

module pulse_width_remote_code_decoder_top_tb;
   import pwrcd_pkg::*;

   localparam int CODE_BITS       = 64;
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES   = 10;    // settle time after nothing is owed, before the next step
   localparam int WATCHDOG_CYCLES = 5000;  // cycles without any beat before giving up
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 8'd200;

   // ---------------------------------------------------------------- DUT hookup
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_payload_type            req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_payload_type            rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   pulse_width_remote_code_decoder_top #(
      .CODE_WIDTH (CODE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- bench state
   req_payload_type pulses_pending[$];   // pulses waiting for the driver
   rsp_payload_type expected_codes[$];   // decoded codes not yet seen on rsp

   int send_idle_pct  = 0;   // chance the driver leaves a cycle empty
   int stall_pct      = 0;   // chance the monitor stalls a cycle
   int mode_sel       = 0;
   int pulses_queued  = 0;
   int pulses_accepted = 0;
   int codes_checked  = 0;
   int csr_writes     = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;
   int hold_left      = 0;
   logic hold_armed   = 1'b0;

   // Decoder shadow: configuration and frame state, reset values as after reset.
   cfg_type                    cfg_shadow = {SHORT_RESET, LONG_RESET, TOL_RESET, MINB_RESET};
   phase_type                  dec_phase  = PHASE_HUNT;
   logic [CODE_BITS-1:0]       dec_shift  = '0;
   logic [BIT_COUNT_WIDTH-1:0] dec_count  = '0;
   logic [DURATION_WIDTH-1:0]  dec_high   = '0;

   // ---------------------------------------------------------------- decoder shadow
   // Inclusive window around a nominal length; signed math, so a window whose lower
   // edge goes negative simply admits every short pulse.
   function automatic bit near_us(input longint center, input longint d);
      longint tol;
      tol = cfg_shadow.tolerance;
      return (d >= center - tol) && (d <= center + tol);
   endfunction

   function automatic void shift_bit(input logic b);
      dec_shift = {dec_shift[CODE_BITS-2:0], b};   // oldest bits fall off the top
      if (dec_count < CODE_BITS) dec_count = dec_count + 1'b1;
   endfunction

   // Advance the shadow by one accepted pulse; a closed frame long enough queues a code.
   function automatic void decode_pulse(input req_payload_type p);
      longint d, s, l, tol, h;
      rsp_payload_type code_word;
      d   = p.duration;
      s   = cfg_shadow.short_interval;
      l   = cfg_shadow.long_interval;
      tol = cfg_shadow.tolerance;
      h   = dec_high;
      case (dec_phase)
         PHASE_WAIT_HIGH: begin
            // lows while waiting for the high half of a bit are ignored
            if (p.level) begin
               dec_high  = p.duration;
               dec_phase = PHASE_WAIT_LOW;
            end
         end
         PHASE_WAIT_LOW: begin
            if (p.level) begin
               dec_phase = PHASE_HUNT;            // two highs in a row
            end else if (d >= s * END_MULT + tol) begin
               // end gap wins even when the low would also match a bit
               if (dec_count >= cfg_shadow.min_bits) begin
                  code_word.code      = dec_shift;
                  code_word.bit_count = dec_count;
                  expected_codes.push_back(code_word);
               end
               dec_shift = '0;
               dec_count = '0;
               dec_phase = PHASE_WAIT_HIGH;
            end else if (near_us(s, h) && near_us(l, d)) begin
               shift_bit(1'b0);
               dec_phase = PHASE_WAIT_HIGH;
            end else if (near_us(l, h) && near_us(s, d)) begin
               shift_bit(1'b1);
               dec_phase = PHASE_WAIT_HIGH;
            end else begin
               dec_phase = PHASE_HUNT;
            end
         end
         default: begin
            if (!p.level && d >= s * PRE_MIN_MULT - tol && d <= s * PRE_MAX_MULT + tol) begin
               dec_phase = PHASE_WAIT_HIGH;
               dec_shift = '0;
               dec_count = '0;
            end else begin
               dec_phase = PHASE_HUNT;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------- pulse driver
   // Feeds pulses_pending; a stalled beat is held unchanged, otherwise valid is
   // picked from the idle setting while pulses are pending.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_pulse(req_data);
            pulses_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (pulses_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pulses_pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- code monitor
   always @(posedge clock) begin : code_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            codes_checked++;
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("unexpected code %h, %0d bits",
                                         rsp_data.code, rsp_data.bit_count));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_data.code !== want.code)
                  report_mismatch($sformatf("code %h, want %h", rsp_data.code, want.code));
               if (rsp_data.bit_count !== want.bit_count)
                  report_mismatch($sformatf("bit_count %0d, want %0d",
                                            rsp_data.bit_count, want.bit_count));
            end
         end
         // hold-off dominates; otherwise random stalls per the current idle setting
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
      end
   end

   // Long receiver hold-off, counted here so the sender keeps going meanwhile.
   always @(posedge clock) begin
      if (hold_armed) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog: no beat for %0d cycles, %0d codes outstanding",
                  idle_cycles, expected_codes.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   task automatic queue_pulse(input logic level, input longint dur);
      req_payload_type p;
      p.level    = level;
      p.duration = (dur < 0) ? '0 : (dur > 65535) ? 16'hFFFF : 16'(dur);
      pulses_pending.push_back(p);
      pulses_queued++;
   endtask

   // random length in [lo, hi], clipped to what the capture can report
   function automatic longint pick_us(input longint lo, input longint hi);
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      if (hi <= lo) return lo;
      return lo + $urandom_range(int'(hi - lo));
   endfunction

   function automatic longint jitter_us(input longint center);
      return pick_us(center - cfg_shadow.tolerance, center + cfg_shadow.tolerance);
   endfunction

   // just outside the window on either side
   function automatic longint off_us(input longint center);
      longint tol;
      tol = cfg_shadow.tolerance;
      return $urandom_range(1) ? center + tol + 1 : center - tol - 1;
   endfunction

   task automatic queue_noise(input int count);
      repeat (count) begin
         queue_pulse($urandom_range(1), $urandom_range(1) ? $urandom_range(65535)
                                                          : $urandom_range(2000));
      end
   endtask

   task automatic queue_broken_pair();
      longint s, l;
      s = cfg_shadow.short_interval;
      l = cfg_shadow.long_interval;
      case ($urandom_range(2))
         0: begin
            queue_pulse(1'b1, jitter_us(s));
            queue_pulse(1'b1, jitter_us(l));
         end
         1: begin
            queue_pulse(1'b1, off_us(s));
            queue_pulse(1'b0, jitter_us(l));
         end
         default: begin
            queue_pulse(1'b1, jitter_us(l));
            queue_pulse(1'b0, off_us(s));
         end
      endcase
   endtask

   // Preamble, nbits bit pairs, stop high and end gap, built for the current setting.
   task automatic queue_frame(input int nbits, input int flaw_pct);
      longint s, l, t;
      logic b;
      s = cfg_shadow.short_interval;
      l = cfg_shadow.long_interval;
      t = cfg_shadow.tolerance;
      queue_pulse(1'b0, pick_us(s * PRE_MIN_MULT - t, s * PRE_MAX_MULT + t));
      for (int i = 0; i < nbits; i++) begin
         b = $urandom_range(1);
         if ($urandom_range(99) < flaw_pct) begin
            queue_broken_pair();
         end else begin
            if ($urandom_range(15) == 0) queue_pulse(1'b0, $urandom_range(65535));
            queue_pulse(1'b1, jitter_us(b ? l : s));
            queue_pulse(1'b0, jitter_us(b ? s : l));
         end
      end
      queue_pulse(1'b1, jitter_us(s));
      queue_pulse(1'b0, pick_us(s * END_MULT + t, s * END_MULT + t + 2 * s));
   endtask

   task automatic set_mode(input int k);
      case (k % 4)
         0:       begin send_idle_pct = 0;  stall_pct = 0;  end
         1:       begin send_idle_pct = 83; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 83; end
         default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
   endtask

   task automatic wait_sent();
      do @(negedge clock); while (pulses_pending.size() != 0);
   endtask

   // block is idle once nothing is queued, offered or owed, plus a short settle
   task automatic drain_block();
      do @(negedge clock);
      while (pulses_pending.size() != 0 || req_valid || expected_codes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_traffic(input int pulses, input int min_len, input int max_len);
      int stop_at;
      stop_at = pulses_queued + pulses;
      while (pulses_queued < stop_at) begin
         if ($urandom_range(99) < 85) queue_frame($urandom_range(max_len, min_len), 3);
         else queue_noise($urandom_range(6, 1));
      end
      wait_sent();
   endtask

   // four chunks, each under the next idle setting, then drain
   task automatic run_phase(input int pulses, input int min_len, input int max_len);
      repeat (4) begin
         set_mode(mode_sel);
         mode_sel++;
         run_traffic(pulses / 4, min_len, max_len);
      end
      drain_block();
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_SHORT_INTERVAL: cfg_shadow.short_interval = value;
         CSR_LONG_INTERVAL:  cfg_shadow.long_interval  = value;
         CSR_TOLERANCE:      cfg_shadow.tolerance      = value[TOL_WIDTH-1:0];
         CSR_MIN_BITS:       cfg_shadow.min_bits       = value[BIT_COUNT_WIDTH-1:0];
         default: ;          // unmapped index, dropped by the block
      endcase
   endtask

   // Directed pass under the reset values (150 / 450 / 50 / 12).
   task automatic queue_directed();
      // hunting: a high, then a low far above the preamble window
      queue_pulse(1'b1, 0);
      queue_pulse(1'b0, 65535);
      // preamble on its lower edge, then 12 bits starting on the window edges
      queue_pulse(1'b0, 4300);
      queue_pulse(1'b1, 100);  queue_pulse(1'b0, 500);   // 0
      queue_pulse(1'b0, 3000);                           // stray low, ignored
      queue_pulse(1'b1, 400);  queue_pulse(1'b0, 200);   // 1
      queue_pulse(1'b1, 200);  queue_pulse(1'b0, 400);   // 0
      queue_pulse(1'b1, 500);  queue_pulse(1'b0, 100);   // 1
      for (int i = 0; i < 8; i++) begin
         if (i % 2) begin
            queue_pulse(1'b1, jitter_us(450)); queue_pulse(1'b0, jitter_us(150));
         end else begin
            queue_pulse(1'b1, jitter_us(150)); queue_pulse(1'b0, jitter_us(450));
         end
      end
      // stop high and end gap exactly on its threshold: 12-bit code out
      queue_pulse(1'b1, 150);
      queue_pulse(1'b0, 1550);
      // low just under the gap that matches nothing: back to hunting
      queue_pulse(1'b1, 100);
      queue_pulse(1'b0, 1549);
      // preamble on its upper edge, then two highs in a row
      queue_pulse(1'b0, 7400);
      queue_pulse(1'b1, 400);
      queue_pulse(1'b1, 400);
      // just outside the preamble window on both sides
      queue_pulse(1'b0, 4299);
      queue_pulse(1'b0, 7401);
   endtask

   // ---------------------------------------------------------------- test sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values: directed, then a hold-off while the sender keeps pushing,
      // then random frames under every idle setting
      set_mode(0);
      queue_directed();
      drain_block();
      @(posedge clock);
      hold_armed <= 1'b1;
      @(posedge clock);
      hold_armed <= 1'b0;
      // a clean frame first so a code sits stalled and the queue backs up
      queue_frame(12, 0);
      run_traffic(60, 12, 16);
      drain_block();
      run_phase(100, 12, 20);

      // tightest timing: 1 us short, 4095 us long, no tolerance. Any long low is
      // past the end gap, so zero bits always close the frame.
      write_reg(CSR_SHORT_INTERVAL, 12'd1);
      write_reg(CSR_LONG_INTERVAL,  12'd4095);
      write_reg(CSR_TOLERANCE,      12'd0);
      write_reg(CSR_MIN_BITS,       12'd1);
      run_phase(60, 1, 10);

      // widest tolerance (written with spare upper bits), full 64-bit frames;
      // longer frames push old bits out and pin the counter at 64
      write_reg(CSR_SHORT_INTERVAL, 12'd2000);
      write_reg(CSR_LONG_INTERVAL,  12'd4095);
      write_reg(CSR_TOLERANCE,      12'hFFF);
      write_reg(CSR_MIN_BITS,       12'd64);
      run_phase(320, 56, 72);

      // min_bits 0: even a frame with no bits reports a code
      write_reg(CSR_SHORT_INTERVAL, 12'd100);
      write_reg(CSR_LONG_INTERVAL,  12'd300);
      write_reg(CSR_TOLERANCE,      12'd0);
      write_reg(CSR_MIN_BITS,       12'd0);
      run_phase(40, 0, 6);

      // min_bits masked to 127: nothing may come out; unmapped index is dropped
      write_reg(CSR_SHORT_INTERVAL, 12'd300);
      write_reg(CSR_LONG_INTERVAL,  12'd700);
      write_reg(CSR_TOLERANCE,      12'd100);
      write_reg(CSR_MIN_BITS,       12'hFFF);
      write_reg(CSR_UNUSED_INDEX,   12'd5);
      run_phase(40, 4, 12);

      // tolerance above the short interval: short window reaches down to zero
      write_reg(CSR_SHORT_INTERVAL, 12'd40);
      write_reg(CSR_TOLERANCE,      12'd100);
      write_reg(CSR_LONG_INTERVAL,  12'd300);
      write_reg(CSR_MIN_BITS,       12'd8);
      run_phase(60, 6, 14);

      // largest short interval: preamble can never fit in 16 bits
      write_reg(CSR_SHORT_INTERVAL, 12'hFFF);
      write_reg(CSR_LONG_INTERVAL,  12'd1);
      run_phase(20, 1, 4);

      $display("covered %0d pulses and %0d decoded codes over 7 register settings (%0d writes)",
               pulses_accepted, codes_checked, csr_writes);
      $display("idle and stall mixes rotated per chunk, one %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
